/* rtl/lsrc_pkg.sv */
`default_nettype none
package lsrc_pkg;

  localparam int CW      = 16;
  localparam int DW      = CW + 1;
  localparam int PW      = 2 * DW;
  localparam int BPS     = 3;
  localparam int DSTAGES = (DW + BPS - 1) / BPS;
  localparam int QN      = DSTAGES * BPS;
  localparam int CLIP_STEPS = 4;

  localparam int OC_LEFT   = 0;
  localparam int OC_RIGHT  = 1;
  localparam int OC_BOTTOM = 2;
  localparam int OC_TOP    = 3;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] wide_t;

  localparam coord_t XMIN_RST = coord_t'(0);
  localparam coord_t XMAX_RST = coord_t'(4095);
  localparam coord_t YMIN_RST = coord_t'(0);
  localparam coord_t YMAX_RST = coord_t'(4095);

  typedef enum logic [1:0] {
    REG_XMIN = 2'd0,
    REG_XMAX = 2'd1,
    REG_YMIN = 2'd2,
    REG_YMAX = 2'd3
  } reg_idx_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    logic   accepted;
    coord_t clip_start_x;
    coord_t clip_start_y;
    coord_t clip_end_x;
    coord_t clip_end_y;
  } out_item_t;

  typedef struct packed {
    coord_t xmin;
    coord_t xmax;
    coord_t ymin;
    coord_t ymax;
  } win_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    logic   done;
    logic   acc;
  } seg_t;

  typedef struct packed {
    seg_t            seg;
    logic            first;
    logic            fix_y;
    coord_t          fixv;
    coord_t          base;
    logic            neg;
    logic            dz;
    logic [DW-1:0]   sm;
    logic [DW-1:0]   nm;
    logic [DW-1:0]   dm;
    logic [PW-1:0]   prod;
    logic [DW-1:0]   rem;
    logic [QN-1:0]   low;
  } work_t;

  function automatic logic [3:0] outcode(coord_t x, coord_t y, win_t w);
    logic [3:0] c;
    c = '0;
    c[OC_LEFT]   = x < w.xmin;
    c[OC_RIGHT]  = x > w.xmax;
    c[OC_BOTTOM] = y < w.ymin;
    c[OC_TOP]    = y > w.ymax;
    return c;
  endfunction

  function automatic logic [DW-1:0] mag(wide_t v);
    logic [DW-1:0] m;
    m = v[DW-1] ? DW'(-v) : DW'(v);
    return m;
  endfunction

endpackage
`default_nettype wire

/* rtl/lsrc_clip_step.sv */
`default_nettype none
module lsrc_clip_step (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire lsrc_pkg::win_t win,
  input  wire logic          in_valid,
  input  wire lsrc_pkg::seg_t in_seg,
  output logic               out_valid,
  output lsrc_pkg::seg_t     out_seg
);

  localparam int DS = lsrc_pkg::DSTAGES;

  lsrc_pkg::work_t sel, sel_next, mul, mul_next;
  logic            sel_v, mul_v;
  lsrc_pkg::work_t div_src [DS];
  lsrc_pkg::work_t div_next[DS];
  lsrc_pkg::work_t div_q   [DS];
  logic            div_v   [DS];
  lsrc_pkg::seg_t  seg_next;

  // Select stage: outcodes, trivial tests, edge choice and operand magnitudes.
  always_comb begin
    logic [3:0] c0, c1, co;
    lsrc_pkg::wide_t sx0, sy0, sx1, sy1, span, num, den;
    c0 = lsrc_pkg::outcode(in_seg.x0, in_seg.y0, win);
    c1 = lsrc_pkg::outcode(in_seg.x1, in_seg.y1, win);
    co = (c0 != 4'd0) ? c0 : c1;
    sx0 = {in_seg.x0[lsrc_pkg::CW-1], in_seg.x0};
    sy0 = {in_seg.y0[lsrc_pkg::CW-1], in_seg.y0};
    sx1 = {in_seg.x1[lsrc_pkg::CW-1], in_seg.x1};
    sy1 = {in_seg.y1[lsrc_pkg::CW-1], in_seg.y1};
    sel_next = '0;
    sel_next.seg = in_seg;
    sel_next.first = c0 != 4'd0;
    if (co[lsrc_pkg::OC_TOP]) begin
      span = sx1 - sx0;
      num  = {win.ymax[lsrc_pkg::CW-1], win.ymax} - sy0;
      den  = sy1 - sy0;
      sel_next.fix_y = 1'b1;
      sel_next.fixv  = win.ymax;
      sel_next.base  = in_seg.x0;
    end else if (co[lsrc_pkg::OC_BOTTOM]) begin
      span = sx1 - sx0;
      num  = {win.ymin[lsrc_pkg::CW-1], win.ymin} - sy0;
      den  = sy1 - sy0;
      sel_next.fix_y = 1'b1;
      sel_next.fixv  = win.ymin;
      sel_next.base  = in_seg.x0;
    end else if (co[lsrc_pkg::OC_RIGHT]) begin
      span = sy1 - sy0;
      num  = {win.xmax[lsrc_pkg::CW-1], win.xmax} - sx0;
      den  = sx1 - sx0;
      sel_next.fix_y = 1'b0;
      sel_next.fixv  = win.xmax;
      sel_next.base  = in_seg.y0;
    end else begin
      span = sy1 - sy0;
      num  = {win.xmin[lsrc_pkg::CW-1], win.xmin} - sx0;
      den  = sx1 - sx0;
      sel_next.fix_y = 1'b0;
      sel_next.fixv  = win.xmin;
      sel_next.base  = in_seg.y0;
    end
    sel_next.sm  = lsrc_pkg::mag(span);
    sel_next.nm  = lsrc_pkg::mag(num);
    sel_next.dm  = lsrc_pkg::mag(den);
    sel_next.neg = span[lsrc_pkg::DW-1] ^ num[lsrc_pkg::DW-1] ^ den[lsrc_pkg::DW-1];
    sel_next.dz  = den == '0;
    if (!in_seg.done) begin
      if ((c0 | c1) == 4'd0) begin
        sel_next.seg.done = 1'b1;
        sel_next.seg.acc  = 1'b1;
      end else if ((c0 & c1) != 4'd0) begin
        sel_next.seg.done = 1'b1;
        sel_next.seg.acc  = 1'b0;
      end
    end
  end

  always_comb begin
    mul_next = sel;
    mul_next.prod = lsrc_pkg::PW'(sel.sm) * lsrc_pkg::PW'(sel.nm);
  end

  // Restoring divider, BPS (three) quotient bits per stage. The quotient is
  // shifted into the low dividend bits as they are consumed.
  for (genvar g = 0; g < DS; g++) begin : g_div
    if (g == 0) begin : g_first
      always_comb begin
        div_src[g] = mul;
        div_src[g].rem = lsrc_pkg::DW'(mul.prod >> lsrc_pkg::QN);
        div_src[g].low = mul.prod[lsrc_pkg::QN-1:0];
      end
    end else begin : g_rest
      assign div_src[g] = div_q[g-1];
    end

    always_comb begin
      logic [lsrc_pkg::DW:0] t;
      div_next[g] = div_src[g];
      for (int i = 0; i < lsrc_pkg::BPS; i++) begin
        t = {div_next[g].rem, div_next[g].low[lsrc_pkg::QN-1]};
        div_next[g].low = {div_next[g].low[lsrc_pkg::QN-2:0], 1'b0};
        if (t >= {1'b0, div_next[g].dm}) begin
          t = t - {1'b0, div_next[g].dm};
          div_next[g].low[0] = 1'b1;
        end
        div_next[g].rem = t[lsrc_pkg::DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_v[g] <= 1'b0;
      end else if (en) begin
        div_v[g] <= (g == 0) ? mul_v : div_v[(g == 0) ? 0 : g-1];
      end
      if (en) begin
        div_q[g] <= div_next[g];
      end
    end
  end

  // Write back the moved endpoint.
  always_comb begin
    lsrc_pkg::work_t w;
    logic signed [lsrc_pkg::QN:0] bx, qx, nv;
    lsrc_pkg::coord_t newv, px, py;
    w  = div_q[DS-1];
    bx = (lsrc_pkg::QN+1)'(w.base);
    qx = $signed({1'b0, w.low});
    nv = w.neg ? (bx - qx) : (bx + qx);
    newv = w.dz ? w.base : nv[lsrc_pkg::CW-1:0];
    px = w.fix_y ? newv : w.fixv;
    py = w.fix_y ? w.fixv : newv;
    seg_next = w.seg;
    if (!w.seg.done) begin
      if (w.first) begin
        seg_next.x0 = px;
        seg_next.y0 = py;
      end else begin
        seg_next.x1 = px;
        seg_next.y1 = py;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_v     <= 1'b0;
      mul_v     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      sel_v     <= in_valid;
      mul_v     <= sel_v;
      out_valid <= div_v[DS-1];
    end
    if (en) begin
      sel     <= sel_next;
      mul     <= mul_next;
      out_seg <= seg_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/line_segment_rectangle_clipper.sv */
// Pipeline: 4 clip steps, each with select, multiply, divider and write-back
// registers, followed by the output register.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// Reset (rst, synchronous, active high) clears all valid bits and loads the
// window registers with their reset values.
`default_nettype none
module line_segment_rectangle_clipper (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lsrc_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lsrc_pkg::out_item_t      out_item,
  input  wire logic                cfg_write,
  input  wire logic [1:0]          cfg_index,
  input  wire lsrc_pkg::coord_t    cfg_data
);

  // The whole pipeline moves as one when the output register can take data.
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Window registers. They must be written only while the pipeline is empty,
  // so every stage may read them directly; the block does not enforce this.
  lsrc_pkg::win_t win;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.xmin <= lsrc_pkg::XMIN_RST;
      win.xmax <= lsrc_pkg::XMAX_RST;
      win.ymin <= lsrc_pkg::YMIN_RST;
      win.ymax <= lsrc_pkg::YMAX_RST;
    end else if (cfg_write) begin
      case (lsrc_pkg::reg_idx_t'(cfg_index))
        lsrc_pkg::REG_XMIN: win.xmin <= cfg_data;
        lsrc_pkg::REG_XMAX: win.xmax <= cfg_data;
        lsrc_pkg::REG_YMIN: win.ymin <= cfg_data;
        lsrc_pkg::REG_YMAX: win.ymax <= cfg_data;
        default: ;
      endcase
    end
  end

  // Each clip step either settles the segment (trivial accept or reject)
  // or moves one outside endpoint onto a window edge. Settled segments
  // ride through the remaining steps untouched.
  lsrc_pkg::seg_t step_seg[lsrc_pkg::CLIP_STEPS+1];
  logic           step_v  [lsrc_pkg::CLIP_STEPS+1];

  always_comb begin
    step_seg[0]    = '0;
    step_seg[0].x0 = in_item.start_x;
    step_seg[0].y0 = in_item.start_y;
    step_seg[0].x1 = in_item.end_x;
    step_seg[0].y1 = in_item.end_y;
  end
  assign step_v[0] = in_valid;

  for (genvar s = 0; s < lsrc_pkg::CLIP_STEPS; s++) begin : g_step
    lsrc_clip_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .win       (win),
      .in_valid  (step_v[s]),
      .in_seg    (step_seg[s]),
      .out_valid (step_v[s+1]),
      .out_seg   (step_seg[s+1])
    );
  end

  // After the last clip step a segment that is still unsettled is
  // accepted only if both endpoints are now inside; anything else rejects.
  lsrc_pkg::out_item_t out_next;

  always_comb begin
    lsrc_pkg::seg_t s;
    logic [3:0] c0, c1;
    logic acc;
    s   = step_seg[lsrc_pkg::CLIP_STEPS];
    c0  = lsrc_pkg::outcode(s.x0, s.y0, win);
    c1  = lsrc_pkg::outcode(s.x1, s.y1, win);
    acc = s.done ? s.acc : ((c0 | c1) == 4'd0);
    out_next.accepted     = acc;
    out_next.clip_start_x = acc ? s.x0 : '0;
    out_next.clip_start_y = acc ? s.y0 : '0;
    out_next.clip_end_x   = acc ? s.x1 : '0;
    out_next.clip_end_y   = acc ? s.y1 : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= step_v[lsrc_pkg::CLIP_STEPS];
    end
    if (en) begin
      out_item <= out_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/lsrc_checker.sv */
`default_nettype none
module lsrc_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire lsrc_pkg::in_item_t  in_item,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire lsrc_pkg::out_item_t out_item
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input item changed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.accepted |->
      out_item.clip_start_x == '0 && out_item.clip_start_y == '0 &&
      out_item.clip_end_x == '0 && out_item.clip_end_y == '0)
    else $error("rejected item has nonzero coordinates");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

endmodule

bind line_segment_rectangle_clipper lsrc_checker u_lsrc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
module testbench;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  lsrc_pkg::in_item_t in_item;
  logic out_valid;
  logic out_stall;
  lsrc_pkg::out_item_t out_item;
  logic cfg_write;
  logic [1:0] cfg_index;
  lsrc_pkg::coord_t cfg_data;

  line_segment_rectangle_clipper i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Scoreboard: carries its own copy of the window and predicts each clipped segment.
  class clip_scoreboard;
    longint wxmin, wxmax, wymin, wymax;
    lsrc_pkg::out_item_t clipped_q[$];
    int mismatches;
    int checked;

    function new();
      wxmin = 0; wxmax = 4095; wymin = 0; wymax = 4095;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_window(lsrc_pkg::reg_idx_t idx, lsrc_pkg::coord_t v);
      case (idx)
        lsrc_pkg::REG_XMIN: wxmin = v;
        lsrc_pkg::REG_XMAX: wxmax = v;
        lsrc_pkg::REG_YMIN: wymin = v;
        lsrc_pkg::REG_YMAX: wymax = v;
        default: ;
      endcase
    endfunction

    function logic [3:0] region(longint x, longint y);
      logic [3:0] c;
      c = '0;
      c[lsrc_pkg::OC_LEFT] = x < wxmin;
      c[lsrc_pkg::OC_RIGHT] = x > wxmax;
      c[lsrc_pkg::OC_BOTTOM] = y < wymin;
      c[lsrc_pkg::OC_TOP] = y > wymax;
      return c;
    endfunction

    // Full-width product, quotient truncated toward zero.
    function longint crossing(longint base, longint span, longint num, longint den);
      longint q;
      if (den == 0) return base;
      q = ((span < 0 ? -span : span) * (num < 0 ? -num : num)) / (den < 0 ? -den : den);
      if (((span < 0) != (num < 0)) != (den < 0)) return base - q;
      return base + q;
    endfunction

    function void note_segment(lsrc_pkg::in_item_t s);
      longint x0, y0, x1, y1, nx, ny;
      logic [3:0] c0, c1, co;
      logic acc;
      lsrc_pkg::coord_t t;
      lsrc_pkg::out_item_t r;
      x0 = s.start_x; y0 = s.start_y; x1 = s.end_x; y1 = s.end_y;
      c0 = region(x0, y0);
      c1 = region(x1, y1);
      acc = 0;
      for (int steps = 0; ; steps++) begin
        if ((c0 | c1) == 0) begin
          acc = 1;
          break;
        end
        if ((c0 & c1) != 0) break;
        if (steps >= lsrc_pkg::CLIP_STEPS) break;
        co = (c0 != 0) ? c0 : c1;
        if (co[lsrc_pkg::OC_TOP]) begin
          nx = crossing(x0, x1 - x0, wymax - y0, y1 - y0); ny = wymax;
        end else if (co[lsrc_pkg::OC_BOTTOM]) begin
          nx = crossing(x0, x1 - x0, wymin - y0, y1 - y0); ny = wymin;
        end else if (co[lsrc_pkg::OC_RIGHT]) begin
          ny = crossing(y0, y1 - y0, wxmax - x0, x1 - x0); nx = wxmax;
        end else begin
          ny = crossing(y0, y1 - y0, wxmin - x0, x1 - x0); nx = wxmin;
        end
        t = lsrc_pkg::coord_t'(nx); nx = t;
        t = lsrc_pkg::coord_t'(ny); ny = t;
        if (c0 != 0) begin
          x0 = nx; y0 = ny; c0 = region(x0, y0);
        end else begin
          x1 = nx; y1 = ny; c1 = region(x1, y1);
        end
      end
      r = '0;
      if (acc) begin
        r.accepted = 1'b1;
        r.clip_start_x = lsrc_pkg::coord_t'(x0);
        r.clip_start_y = lsrc_pkg::coord_t'(y0);
        r.clip_end_x = lsrc_pkg::coord_t'(x1);
        r.clip_end_y = lsrc_pkg::coord_t'(y1);
      end
      clipped_q = {clipped_q, r};
    endfunction

    function void check_result(lsrc_pkg::out_item_t got);
      lsrc_pkg::out_item_t want;
      if (clipped_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = clipped_q.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want acc=%b %0d %0d %0d %0d, got acc=%b %0d %0d %0d %0d",
                   want.accepted, want.clip_start_x, want.clip_start_y, want.clip_end_x,
                   want.clip_end_y, got.accepted, got.clip_start_x, got.clip_start_y,
                   got.clip_end_x, got.clip_end_y);
      end
    endfunction
  endclass

  clip_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_output;
  int segments_sent;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: stalls at the phase's rate, or for a long stretch when asked.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(out_item);
      out_stall <= hold_output || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Drives one register write; the caller drops the write enable afterwards.
  task automatic write_window(lsrc_pkg::reg_idx_t idx, lsrc_pkg::coord_t v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_window(idx, v);
  endtask

  // Offers one item and holds it until the block takes it. Valid stays high
  // afterwards; the next call or the caller decides what follows.
  task automatic send_segment(lsrc_pkg::in_item_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_segment(s);
    segments_sent++;
  endtask

  // Waits for every expected item, then lets the pipeline drain fully.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.clipped_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  function automatic lsrc_pkg::coord_t pick_coord();
    case ($urandom_range(5))
      0: return lsrc_pkg::coord_t'($urandom);
      1: return $urandom_range(1) ? lsrc_pkg::coord_t'(16'sh7fff)
                                  : lsrc_pkg::coord_t'(16'sh8000);
      default: return lsrc_pkg::coord_t'($urandom_range(5000) - 500);
    endcase
  endfunction

  task automatic send_random(int n);
    lsrc_pkg::in_item_t s;
    for (int i = 0; i < n; i++) begin
      s.start_x = pick_coord();
      s.start_y = pick_coord();
      s.end_x = pick_coord();
      s.end_y = pick_coord();
      send_segment(s);
    end
  endtask

  task automatic set_window(lsrc_pkg::coord_t x0, lsrc_pkg::coord_t x1,
                            lsrc_pkg::coord_t y0, lsrc_pkg::coord_t y1);
    write_window(lsrc_pkg::REG_XMIN, x0);
    write_window(lsrc_pkg::REG_XMAX, x1);
    write_window(lsrc_pkg::REG_YMIN, y0);
    write_window(lsrc_pkg::REG_YMAX, y1);
    cfg_write <= 1'b0;
  endtask

  initial begin
    lsrc_pkg::in_item_t s;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_write = 1'b0;
    cfg_index = lsrc_pkg::REG_XMIN;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_output = 0;
    segments_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: inside, on edges, trivial reject, crossings of each edge, extremes.
    s = '{100, 100, 200, 200};        send_segment(s);
    s = '{0, 0, 4095, 4095};          send_segment(s);
    s = '{-100, 5000, -50, 6000};     send_segment(s);
    s = '{2000, -1000, 2000, 6000};   send_segment(s);
    s = '{-1000, 2000, 6000, 2100};   send_segment(s);
    s = '{-1000, -1000, 6000, 6000};  send_segment(s);
    s = '{-500, 3000, 3000, 5000};    send_segment(s);
    s = '{-32768, -32768, 32767, 32767}; send_segment(s);
    s = '{32767, -32768, -32768, 32767}; send_segment(s);
    s = '{-200, 4500, 300, 4200};     send_segment(s);
    s = '{5000, 5000, 5000, 5000};    send_segment(s);
    s = '{-1, 4096, 4096, -1};        send_segment(s);
    drain();
    // Extreme and inverted windows.
    set_window(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_random(30);
    drain();
    set_window(100, -100, 0, 4095);
    send_random(20);
    drain();
    set_window(-300, 700, -50, 900);
    s = '{-32768, 0, 32767, 0};       send_segment(s);

    send_random(100);
    send_idle_pct = 59;
    send_random(100);
    send_idle_pct = 0; recv_stall_pct = 59;
    send_random(100);
    send_idle_pct = 27; recv_stall_pct = 27;
    send_random(80);
    drain();
    set_window(0, 0, 0, 0);
    send_random(20);
    drain();
    set_window(-4000, 3000, -2000, 2500);
    // Long output hold while the sender keeps offering, so the pipeline fills.
    send_idle_pct = 0; recv_stall_pct = 0;
    fork
      begin
        send_random(80);
        in_valid <= 1'b0;
      end
      begin
        hold_output = 1;
        repeat (200) @(posedge clk);
        hold_output = 0;
      end
    join
    drain();

    $display("Clipped %0d segments over several windows, including inverted and full-range ones,",
             segments_sent);
    $display("with idle sender, stalling receiver and a long output hold.");
    if (sb.mismatches == 0 && sb.clipped_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
